// ===== src/mbe_pkg.sv =====
// Shared constants, types and arithmetic helpers for the Mandelbrot escape-time block.
package mbe_pkg;

	localparam int FRAC_BITS = 28;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int ITER_W    = 16;

	localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(256);
	localparam logic [PROD_W-1:0] MAG_LIMIT      = PROD_W'(4) << (2 * FRAC_BITS);

	localparam logic signed [PROD_W-1:0] SAT_HI =
		PROD_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
	localparam logic signed [PROD_W-1:0] SAT_LO =
		PROD_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}));

	typedef struct packed {
		logic load;
		logic mul;
		logic add;
		logic upd;
	} cmd_t;

	typedef struct packed {
		logic stop;
	} status_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[DATA_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== src/mbe_point_if.sv =====
// Input channel: one complex point per beat.
interface mbe_point_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [mbe_pkg::DATA_W-1:0]      c_re;
	logic signed [mbe_pkg::DATA_W-1:0]      c_im;

	modport source (output valid, output c_re, output c_im, input ready);
	modport sink   (input valid, input c_re, input c_im, output ready);
endinterface

// ===== src/mbe_result_if.sv =====
// Output channel: one iteration count per beat.
interface mbe_result_if;
	logic                         valid;
	logic                         ready;
	logic [mbe_pkg::ITER_W-1:0]   iterations;

	modport source (output valid, output iterations, input ready);
	modport sink   (input valid, input iterations, output ready);
endinterface

// ===== src/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time block: controller plus datapath.
//
//   channel   | dir | payload              | beat taken when
//   ----------+-----+----------------------+------------------------------
//   point     | in  | c_re, c_im (Q4.28)   | point.valid && point.ready
//   result    | out | iterations (16 bits) | result.valid && result.ready
//   max_iter  | in  | max_iter_wdata       | max_iter_we (write only)
//
// From accept to result beat, each iteration is one multiply, one add and one
// update step, followed by one final limit and escape check, and then the
// result is presented; the next point can be taken in the cycle after the
// result beat. The dependency of z on its own products through a single set
// of multipliers keeps the iterations in sequence. One point is in flight at
// a time.
// Reset clears the controller and restores max_iter to 256.
// A stalled result holds in place; no new point is taken until it leaves.
module mandelbrot_escape_time (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         max_iter_we,
	input  logic [mbe_pkg::ITER_W-1:0]   max_iter_wdata,
	mbe_point_if.sink                    point,
	mbe_result_if.source                 result
);

	mbe_pkg::cmd_t    cmd;
	mbe_pkg::status_t status;

	// sequencing: accept, iterate until limit or escape, present count
	mbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point.valid),
		.in_ready  (point.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// arithmetic: z = z*z + c with saturation, |z|^2 against 4.0
	mbe_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.max_iter_we    (max_iter_we),
		.max_iter_wdata (max_iter_wdata),
		.c_re           (point.c_re),
		.c_im           (point.c_im),
		.iterations     (result.iterations)
	);

endmodule

// ===== src/mbe_dp.sv =====
// Datapath: z registers, products, |z|^2, update with saturation, iteration count.
module mbe_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mbe_pkg::cmd_t                       cmd,
	output mbe_pkg::status_t                    status,
	input  logic                                max_iter_we,
	input  logic [mbe_pkg::ITER_W-1:0]          max_iter_wdata,
	input  logic signed [mbe_pkg::DATA_W-1:0]   c_re,
	input  logic signed [mbe_pkg::DATA_W-1:0]   c_im,
	output logic [mbe_pkg::ITER_W-1:0]          iterations
);

	logic [mbe_pkg::ITER_W-1:0]          max_iter_q;
	logic [mbe_pkg::ITER_W-1:0]          iter_q;
	logic                                esc_q;
	logic signed [mbe_pkg::DATA_W-1:0]   cre_q, cim_q, x_q, y_q;
	logic signed [mbe_pkg::PROD_W-1:0]   xx_q, yy_q, xy_q, diff_q;
	logic [mbe_pkg::PROD_W-1:0]          mag_q;
	logic signed [mbe_pkg::PROD_W-1:0]   nx, ny;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= mbe_pkg::MAX_ITER_RESET;
		end else if (max_iter_we) begin
			max_iter_q <= max_iter_wdata;
		end
	end

	// floor shift is an arithmetic shift; add c at full width, then clamp
	always_comb begin
		nx = (diff_q >>> mbe_pkg::FRAC_BITS) + mbe_pkg::PROD_W'(cre_q);
		ny = (xy_q >>> (mbe_pkg::FRAC_BITS - 1)) + mbe_pkg::PROD_W'(cim_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			esc_q  <= 1'b0;
		end else if (cmd.load) begin
			iter_q <= '0;
			esc_q  <= 1'b0;
		end else if (cmd.upd) begin
			iter_q <= iter_q + 1'b1;
			esc_q  <= (mag_q > mbe_pkg::MAG_LIMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cre_q <= c_re;
			cim_q <= c_im;
			x_q   <= '0;
			y_q   <= '0;
		end else if (cmd.upd) begin
			x_q <= mbe_pkg::sat32(nx);
			y_q <= mbe_pkg::sat32(ny);
		end
		if (cmd.mul) begin
			xx_q <= mbe_pkg::PROD_W'(x_q) * mbe_pkg::PROD_W'(x_q);
			yy_q <= mbe_pkg::PROD_W'(y_q) * mbe_pkg::PROD_W'(y_q);
			xy_q <= mbe_pkg::PROD_W'(x_q) * mbe_pkg::PROD_W'(y_q);
		end
		if (cmd.add) begin
			diff_q <= xx_q - yy_q;
			mag_q  <= xx_q + yy_q;
		end
	end

	assign status.stop = esc_q || (iter_q == max_iter_q);
	assign iterations  = iter_q;

endmodule

// ===== src/mbe_ctrl.sv =====
// Controller: sequences the load step per point, multiply, add and update steps per iteration, then the result.
module mbe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mbe_pkg::cmd_t     cmd,
	input  mbe_pkg::status_t  status
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_ADD  = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       acc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign acc       = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				// check the limit and escape flag before starting an iteration
				if (status.stop) begin
					state_d = S_OUT;
				end else begin
					cmd.mul = 1'b1;
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_MUL;
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_acc_starts: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q == S_MUL)
		else $error("accepted point did not start iterating");

	a_add_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADD |=> state_q == S_UPD)
		else $error("add step not followed by update");

	a_stop_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL && status.stop) |=> state_q == S_OUT)
		else $error("stop seen but no result presented");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while result pending");

endmodule
